// ===== sv/linear_svm_sgd_trainer_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef LINEAR_SVM_SGD_TRAINER_ASSERT_SVH
`define LINEAR_SVM_SGD_TRAINER_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define LSVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LSVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/lsvm_pkg.sv =====
`timescale 1ns / 1ps
package lsvm_pkg;

  localparam int DATA_W     = 32;
  localparam int SUM_W      = 40;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 16;
  localparam int ITER_W     = 32;
  localparam int MUL_W      = 33;
  localparam int BS_W       = 9;
  localparam int FC_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_NUM_W  = SUM_W + FRAC_W;
  localparam int DIV_DEN_W  = 64;

  localparam int MAX_FEATURES_DEF = 64;
  localparam int MAX_BATCH_DEF    = 256;

  localparam logic [CFG_DATA_W-1:0] LAMBDA_RESET = 32'd655;
  localparam logic [BS_W-1:0]       BATCH_RESET  = 9'd1;
  localparam logic [FC_W-1:0]       FCOUNT_RESET = 7'd64;

  localparam logic [1:0] OP_TRAIN   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/linear_svm_sgd_trainer.sv =====
// A feature that does not end its sample passes S_FMUL and S_FACC and returns to idle; a
// sample end goes to S_OUT (through S_BATCH for a train sample), with a sum read and write per
// feature on a margin violation, plus two divisions per weight when it closes a batch.
// Throughput: one item at a time; in_ready is high only between items.
// Reset (synchronous, active low) zeros the model, counters and pending result, and loads
// the register defaults; the model memories are cleared at once through valid bits.
`timescale 1ns / 1ps
module linear_svm_sgd_trainer #(
  parameter int MAX_FEATURES = lsvm_pkg::MAX_FEATURES_DEF,
  parameter int MAX_BATCH    = lsvm_pkg::MAX_BATCH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_en,
  input  logic [lsvm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsvm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_operation,
  input  logic signed [lsvm_pkg::DATA_W-1:0]   in_feature_value,
  input  logic                                 in_label,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_predicted_class,
  output logic                                 out_margin_violated,
  output logic                                 out_weights_updated,
  output logic [lsvm_pkg::ITER_W-1:0]          out_iteration
);

  localparam int DW      = lsvm_pkg::DATA_W;
  localparam int SW      = lsvm_pkg::SUM_W;
  localparam int AW      = lsvm_pkg::ACC_W;
  localparam int IW      = lsvm_pkg::ITER_W;
  localparam int MW      = lsvm_pkg::MUL_W;
  localparam int NW      = lsvm_pkg::DIV_NUM_W;
  localparam int ADDR_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int POS_W   = $clog2(MAX_FEATURES + 1);
  localparam int BATCH_W = $clog2(MAX_BATCH + 1);
  localparam int LK_W    = 32 + BATCH_W;
  localparam int D_W     = LK_W + IW;
  localparam int VW      = NW + 2;

  localparam logic signed [AW-1:0] ONE_Q32  = 64'sd4294967296;
  localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [SW-1:0] SUM_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [VW-1:0] WV_MAX   = VW'($signed(32'h7fff_ffff));
  localparam logic signed [VW-1:0] WV_MIN   = VW'($signed(32'h8000_0000));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FMUL   = 4'd1;
  localparam logic [3:0] S_FACC   = 4'd2;
  localparam logic [3:0] S_SUM_RD = 4'd3;
  localparam logic [3:0] S_SUM_WR = 4'd4;
  localparam logic [3:0] S_BATCH  = 4'd5;
  localparam logic [3:0] S_LK     = 4'd6;
  localparam logic [3:0] S_LK2    = 4'd7;
  localparam logic [3:0] S_D2     = 4'd8;
  localparam logic [3:0] S_D3     = 4'd9;
  localparam logic [3:0] S_URD    = 4'd10;
  localparam logic [3:0] S_UDIV1  = 4'd11;
  localparam logic [3:0] S_UWAIT1 = 4'd12;
  localparam logic [3:0] S_UWAIT2 = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Configuration registers.
  logic [lsvm_pkg::CFG_DATA_W-1:0] lam_r;
  logic [lsvm_pkg::BS_W-1:0]       bs_r;
  logic [lsvm_pkg::FC_W-1:0]       fc_r;

  // Control and datapath registers.
  logic                   train_r;
  logic                   label_r;
  logic signed [DW-1:0]   x_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       len_r;
  logic [ADDR_W-1:0]      idx_r;
  logic [BATCH_W-1:0]     sib_r;
  logic [IW-1:0]          iter_r;
  logic signed [AW-1:0]   dot_r;
  logic signed [AW-1:0]   dotfin_r;
  logic                   viol_r;
  logic                   upd_r;
  logic signed [2*MW-1:0] prod_r;
  logic [LK_W-1:0]        lk_r;
  logic [63:0]            dlo_r;
  logic [63:0]            d_r;
  logic                   dovf_r;
  logic signed [DW-1:0]   w_r;
  logic signed [SW-1:0]   s_r;
  logic [NW-1:0]          q1_r;

  logic       out_valid_r;
  logic       out_pc_r;
  logic       out_mv_r;
  logic       out_wu_r;
  logic [IW-1:0] out_iter_r;

  // Model memories.
  logic [DW-1:0] wmem [MAX_FEATURES];
  logic [SW-1:0] smem [MAX_FEATURES];
  logic [DW-1:0] bmem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] wv_r;
  logic [MAX_FEATURES-1:0] sv_r;
  logic [DW-1:0] w_q;
  logic [SW-1:0] s_q;
  logic [DW-1:0] b_q;
  logic          w_vq;
  logic          s_vq;

  logic                  in_fire;
  logic                  feat_fire;
  logic                  clear_fire;
  logic [ADDR_W-1:0]     w_raddr;
  logic                  w_we;
  logic                  s_we;
  logic signed [DW-1:0]  w_eff;
  logic signed [SW-1:0]  s_eff;
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [AW:0]    acc_add;
  logic signed [AW-1:0]  dot_new;
  logic                  viol_c;
  logic [POS_W-1:0]      cnt_eff;
  logic [BATCH_W-1:0]    bat_eff;
  logic [31:0]           lam_eff;
  logic signed [SW:0]    sum_add;
  logic signed [SW-1:0]  sum_new;
  logic [D_W-1:0]        dsum;
  logic [DW:0]           wabs;
  logic [SW:0]           sabs;
  logic signed [VW-1:0]  t1;
  logic signed [VW-1:0]  t2;
  logic signed [VW-1:0]  vsum;
  logic signed [DW-1:0]  w_new;
  logic [NW-1:0]         q2;
  logic                  last_feat;
  logic                  last_sum;
  logic                  batch_done;
  lsvm_pkg::div_req_t    div_req;
  lsvm_pkg::div_rsp_t    div_rsp;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign feat_fire  = in_fire && (in_operation == lsvm_pkg::OP_TRAIN ||
                                  in_operation == lsvm_pkg::OP_PREDICT);
  assign clear_fire = in_fire && (in_operation == lsvm_pkg::OP_CLEAR);

  // Effective register values after range limiting.
  always_comb begin
    if (fc_r == '0) begin
      cnt_eff = POS_W'(1);
    end else if (int'(fc_r) > MAX_FEATURES) begin
      cnt_eff = POS_W'(MAX_FEATURES);
    end else begin
      cnt_eff = POS_W'(fc_r);
    end
    if (bs_r == '0) begin
      bat_eff = BATCH_W'(1);
    end else if (int'(bs_r) > MAX_BATCH) begin
      bat_eff = BATCH_W'(MAX_BATCH);
    end else begin
      bat_eff = BATCH_W'(bs_r);
    end
    lam_eff = (lam_r == '0) ? 32'd1 : lam_r;
  end

  assign w_eff = w_vq ? $signed(w_q) : '0;
  assign s_eff = s_vq ? $signed(s_q) : '0;

  // Saturating dot accumulate and margin test.
  assign acc_add = (AW+1)'(dot_r) + (AW+1)'($signed(prod_r[AW-1:0]));
  always_comb begin
    if (acc_add[AW] != acc_add[AW-1]) begin
      dot_new = acc_add[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      dot_new = acc_add[AW-1:0];
    end
  end
  assign viol_c = label_r ? (dot_new < ONE_Q32) : (dot_new > -ONE_Q32);

  assign last_feat  = ({1'b0, pos_r} + 1'b1) >= {1'b0, cnt_eff};
  assign last_sum   = ({1'b0, POS_W'(idx_r)} + 1'b1) == {1'b0, len_r};
  assign batch_done = ({1'b0, sib_r} + 1'b1) >= {1'b0, bat_eff};

  // Label-signed batch sum update.
  assign sum_add = (SW+1)'(s_eff) +
                   (label_r ? (SW+1)'($signed(b_q)) : -(SW+1)'($signed(b_q)));
  always_comb begin
    if (sum_add[SW] != sum_add[SW-1]) begin
      sum_new = sum_add[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = sum_add[SW-1:0];
    end
  end

  // Combine the two partial products of lambda * k * t.
  assign dsum = D_W'(dlo_r) + {prod_r[D_W-33:0], 32'd0};

  // Weight update: w - trunc(w / t) + trunc(S * 2^16 / D).
  assign wabs = w_eff[DW-1] ? -(DW+1)'(w_eff) : (DW+1)'(w_eff);
  assign sabs = s_r[SW-1] ? -(SW+1)'(s_r) : (SW+1)'(s_r);
  assign q2   = dovf_r ? '0 : div_rsp.quo;
  assign t1   = w_r[DW-1] ? -$signed(VW'(q1_r)) : $signed(VW'(q1_r));
  assign t2   = s_r[SW-1] ? -$signed(VW'(q2)) : $signed(VW'(q2));
  assign vsum = VW'(w_r) - t1 + t2;
  always_comb begin
    if (vsum > WV_MAX) begin
      w_new = WV_MAX[DW-1:0];
    end else if (vsum < WV_MIN) begin
      w_new = WV_MIN[DW-1:0];
    end else begin
      w_new = vsum[DW-1:0];
    end
  end

  // Shared divider requests.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NW'(wabs[DW-1:0]);
    div_req.den   = lsvm_pkg::DIV_DEN_W'(iter_r);
    if (state_r == S_UDIV1) begin
      div_req.start = 1'b1;
    end else if (state_r == S_UWAIT1) begin
      div_req.start = div_rsp.done;
      div_req.num   = {sabs[SW-1:0], lsvm_pkg::FRAC_W'(0)};
      div_req.den   = d_r;
    end
  end

  lsvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_FMUL: begin
        mul_a = MW'(w_eff);
        mul_b = MW'(x_r);
      end
      S_LK: begin
        mul_a = $signed({1'b0, lam_eff});
        mul_b = $signed(MW'(bat_eff));
      end
      S_LK2: begin
        mul_a = $signed({1'b0, prod_r[31:0]});
        mul_b = $signed({1'b0, iter_r});
      end
      S_D2: begin
        mul_a = $signed(MW'(lk_r[LK_W-1:32]));
        mul_b = $signed({1'b0, iter_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign w_raddr = (state_r == S_IDLE) ? pos_r[ADDR_W-1:0] : idx_r;
  assign w_we    = (state_r == S_UWAIT2) && div_rsp.done;
  assign s_we    = (state_r == S_SUM_WR);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[idx_r] <= w_new;
    end
    w_q  <= wmem[w_raddr];
    w_vq <= wv_r[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[idx_r] <= sum_new;
    end
    s_q  <= smem[idx_r];
    s_vq <= sv_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (feat_fire) begin
      bmem[pos_r[ADDR_W-1:0]] <= in_feature_value;
    end
    b_q <= bmem[idx_r];
  end

  // Entry valid bits: an invalid entry reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_fire) begin
      wv_r <= '0;
      sv_r <= '0;
    end else begin
      if (s_we) begin
        sv_r[idx_r] <= 1'b1;
      end
      if (w_we) begin
        wv_r[idx_r] <= 1'b1;
        sv_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= lsvm_pkg::LAMBDA_RESET;
      bs_r  <= lsvm_pkg::BATCH_RESET;
      fc_r  <= lsvm_pkg::FCOUNT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        lsvm_pkg::CFG_LAMBDA: lam_r <= cfg_data;
        lsvm_pkg::CFG_BATCH:  bs_r  <= cfg_data[lsvm_pkg::BS_W-1:0];
        lsvm_pkg::CFG_FCOUNT: fc_r  <= cfg_data[lsvm_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   state_nxt = feat_fire ? S_FMUL : S_IDLE;
      S_FMUL:   state_nxt = S_FACC;
      S_FACC: begin
        if (!last_feat) begin
          state_nxt = S_IDLE;
        end else if (!train_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = viol_c ? S_SUM_RD : S_BATCH;
        end
      end
      S_SUM_RD: state_nxt = S_SUM_WR;
      S_SUM_WR: state_nxt = last_sum ? S_BATCH : S_SUM_RD;
      S_BATCH:  state_nxt = batch_done ? S_LK : S_OUT;
      S_LK:     state_nxt = S_LK2;
      S_LK2:    state_nxt = S_D2;
      S_D2:     state_nxt = S_D3;
      S_D3:     state_nxt = S_URD;
      S_URD:    state_nxt = S_UDIV1;
      S_UDIV1:  state_nxt = S_UWAIT1;
      S_UWAIT1: state_nxt = div_rsp.done ? S_UWAIT2 : S_UWAIT1;
      S_UWAIT2: begin
        if (div_rsp.done) begin
          state_nxt = (idx_r == ADDR_W'(MAX_FEATURES - 1)) ? S_OUT : S_URD;
        end
      end
      S_OUT:    state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      sib_r       <= '0;
      iter_r      <= '0;
      dot_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // In S_OUT the result register is reloaded below instead.
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_operation)
              lsvm_pkg::OP_TRAIN, lsvm_pkg::OP_PREDICT: begin
                train_r <= (in_operation == lsvm_pkg::OP_TRAIN);
                label_r <= in_label;
                x_r     <= in_feature_value;
              end
              lsvm_pkg::OP_CLEAR: begin
                dot_r  <= '0;
                pos_r  <= '0;
                sib_r  <= '0;
                iter_r <= '0;
              end
              lsvm_pkg::OP_NONE: ;
              default: ;
            endcase
          end
        end
        S_FACC: begin
          if (!last_feat) begin
            pos_r <= pos_r + 1'b1;
            dot_r <= dot_new;
          end else begin
            dotfin_r <= dot_new;
            dot_r    <= '0;
            pos_r    <= '0;
            len_r    <= POS_W'(pos_r + 1'b1);
            idx_r    <= '0;
            viol_r   <= train_r && viol_c;
            upd_r    <= 1'b0;
          end
        end
        S_SUM_WR: begin
          if (!last_sum) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_BATCH: begin
          if (batch_done) begin
            sib_r <= '0;
            upd_r <= 1'b1;
            if (iter_r != '1) begin
              iter_r <= iter_r + 1'b1;
            end
          end else begin
            sib_r <= sib_r + 1'b1;
          end
        end
        S_LK2: lk_r <= prod_r[LK_W-1:0];
        S_D2:  dlo_r <= prod_r[63:0];
        S_D3: begin
          d_r    <= dsum[63:0];
          dovf_r <= |dsum[D_W-1:64];
          idx_r  <= '0;
        end
        S_UDIV1: begin
          w_r <= w_eff;
          s_r <= s_eff;
        end
        S_UWAIT1: begin
          if (div_rsp.done) begin
            q1_r <= div_rsp.quo;
          end
        end
        S_UWAIT2: begin
          if (div_rsp.done && idx_r != ADDR_W'(MAX_FEATURES - 1)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= (dotfin_r > 0);
            out_mv_r    <= viol_r;
            out_wu_r    <= upd_r;
            out_iter_r  <= iter_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_pc_r;
  assign out_margin_violated = out_mv_r;
  assign out_weights_updated = out_wu_r;
  assign out_iteration       = out_iter_r;

endmodule

// ===== sv/lsvm_div.sv =====
`timescale 1ns / 1ps
module lsvm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lsvm_pkg::div_req_t  req,
  output lsvm_pkg::div_rsp_t  rsp
);

  localparam int NW = lsvm_pkg::DIV_NUM_W;
  localparam int DW = lsvm_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          take;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign take   = req.start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      if (!diff[DW+1]) begin
        rem_r <= diff[DW-1:0];
      end else begin
        rem_r <= rem_sh[DW-1:0];
      end
      quo_r <= {quo_r[NW-2:0], !diff[DW+1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== sv/lsvm_checker.sv =====
`timescale 1ns / 1ps
`include "linear_svm_sgd_trainer_assert.svh"
module lsvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_weights_updated,
  input logic [31:0] out_iteration
);

  `LSVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LSVM_ASSERT_SAME(a_upd_iter, out_valid && out_weights_updated, out_iteration != 32'd0, "update with zero iteration")
  `LSVM_ASSERT_NEXT(a_feat_busy, in_valid && in_ready && (in_operation == lsvm_pkg::OP_TRAIN || in_operation == lsvm_pkg::OP_PREDICT), !in_ready, "ready right after a feature transfer")
  `LSVM_ASSERT_NEXT(a_clear_idle, in_valid && in_ready && in_operation == lsvm_pkg::OP_CLEAR, in_ready, "clear left the block busy")

endmodule

bind linear_svm_sgd_trainer lsvm_checker u_lsvm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_operation        (in_operation),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_weights_updated (out_weights_updated),
  .out_iteration       (out_iteration)
);

// ===== test/linear_svm_sgd_trainer_tb.sv =====
`timescale 1ns / 1ps
module linear_svm_sgd_trainer_tb;
  import lsvm_pkg::*;

  localparam int NFEAT      = MAX_FEATURES_DEF;
  localparam int NBATCH     = MAX_BATCH_DEF;
  localparam int STALL_LIMIT = 50000;
  localparam int LONG_HOLD  = 300;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;
  localparam longint ONE_Q  = 64'sd4294967296;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic               lbl;
  } sample_item_t;

  typedef struct packed {
    logic        cls;
    logic        viol;
    logic        upd;
    logic [31:0] iter;
  } svm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_TRAIN;
  logic signed [DATA_W-1:0] in_feature_value = '0;
  logic in_label = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_predicted_class;
  logic out_margin_violated;
  logic out_weights_updated;
  logic [ITER_W-1:0] out_iteration;

  linear_svm_sgd_trainer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_feature_value(in_feature_value), .in_label(in_label),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_predicted_class(out_predicted_class), .out_margin_violated(out_margin_violated),
    .out_weights_updated(out_weights_updated), .out_iteration(out_iteration)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trainer state as the testbench expects it.
  logic [31:0] lambda_reg = LAMBDA_RESET;
  logic [8:0] batch_reg = BATCH_RESET;
  logic [6:0] fcount_reg = FCOUNT_RESET;
  logic signed [31:0] weight_mem [NFEAT];
  longint sum_mem [NFEAT];
  logic signed [31:0] feature_mem [NFEAT];
  longint dot_acc = 0;
  int feat_pos = 0;
  int batch_fill = 0;
  logic [31:0] update_count = '0;

  sample_item_t feature_queue[$];
  svm_result_t result_queue[$];
  int errors = 0;
  int stall_cycles = 0;
  logic in_taken = 1'b0;
  logic idle_off = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint sum_share(longint s, longint unsigned l, longint unsigned t,
                                       longint unsigned k);
    longint unsigned mag, num, lk, q;
    mag = (s < 0) ? longint'(-s) : s;
    num = mag << 16;
    lk = l * k;
    if (lk > 64'hFFFF_FFFF_FFFF_FFFF / t) return 0;
    q = num / (lk * t);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void apply_batch_update();
    longint unsigned l, k, t;
    longint w, v;
    l = (lambda_reg == 0) ? 1 : lambda_reg;
    k = (batch_reg == 0) ? 1 : ((batch_reg > NBATCH) ? NBATCH : batch_reg);
    t = update_count;
    for (int i = 0; i < NFEAT; i++) begin
      w = weight_mem[i];
      v = w - w / longint'(t) + sum_share(sum_mem[i], l, t, k);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      weight_mem[i] = v[31:0];
      sum_mem[i] = 0;
    end
  endfunction

  function automatic void clear_trainer();
    for (int i = 0; i < NFEAT; i++) begin
      weight_mem[i] = '0;
      sum_mem[i] = 0;
    end
    dot_acc = 0;
    feat_pos = 0;
    batch_fill = 0;
    update_count = '0;
  endfunction

  function automatic void trainer_step(sample_item_t it);
    int cnt, bsz, len;
    logic signed [64:0] wide;
    longint dot, v;
    svm_result_t r;
    if (it.op == OP_CLEAR) begin
      clear_trainer();
      return;
    end
    if (it.op == OP_NONE) return;
    cnt = (fcount_reg == 0) ? 1 : ((fcount_reg > NFEAT) ? NFEAT : fcount_reg);
    if (feat_pos >= NFEAT) feat_pos = NFEAT - 1;
    feature_mem[feat_pos] = it.x;
    wide = 65'(dot_acc) + 65'(longint'(weight_mem[feat_pos]) * longint'(it.x));
    if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) dot_acc = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (wide < -65'sh0_8000_0000_0000_0000) dot_acc = 64'h8000_0000_0000_0000;
    else dot_acc = wide[63:0];
    if (feat_pos + 1 < cnt) begin
      feat_pos++;
      return;
    end
    dot = dot_acc;
    len = feat_pos + 1;
    dot_acc = 0;
    feat_pos = 0;
    r = '0;
    if (it.op == OP_TRAIN) begin
      r.viol = it.lbl ? (dot < ONE_Q) : (dot > -ONE_Q);
      if (r.viol) begin
        for (int i = 0; i < len; i++) begin
          v = sum_mem[i] + (it.lbl ? longint'(feature_mem[i]) : -longint'(feature_mem[i]));
          if (v > SUM_HI) v = SUM_HI;
          if (v < SUM_LO) v = SUM_LO;
          sum_mem[i] = v;
        end
      end
      bsz = (batch_reg == 0) ? 1 : ((batch_reg > NBATCH) ? NBATCH : batch_reg);
      batch_fill++;
      if (batch_fill >= bsz) begin
        if (update_count != 32'hFFFF_FFFF) update_count++;
        apply_batch_update();
        batch_fill = 0;
        r.upd = 1'b1;
      end
    end
    r.cls = dot > 0;
    r.iter = update_count;
    result_queue.push_back(r);
  endfunction

  // Input side: a new item goes out only once the previous transfer is done.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (feature_queue.size() > 0) begin
        sample_item_t it;
        it = feature_queue.pop_front();
        in_operation <= it.op;
        in_feature_value <= it.x;
        in_label <= it.lbl;
        in_valid <= 1'b1;
        if (!idle_off && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts plus one long hold counted here.
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!idle_off && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result transfer with nothing expected at %0t", $realtime);
        end else begin
          svm_result_t e;
          e = result_queue.pop_front();
          if (e.cls !== out_predicted_class || e.viol !== out_margin_violated ||
              e.upd !== out_weights_updated || e.iter !== out_iteration) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: expected cls=%0b viol=%0b upd=%0b iter=%0d, got %0b %0b %0b %0d",
                       $realtime, e.cls, e.viol, e.upd, e.iter, out_predicted_class,
                       out_margin_violated, out_weights_updated, out_iteration);
          end
        end
      end
      if (in_valid && in_ready)
        trainer_step(sample_item_t'{op: in_operation, x: in_feature_value, lbl: in_label});
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_LAMBDA: lambda_reg = val;
      CFG_BATCH:  batch_reg = val[8:0];
      CFG_FCOUNT: fcount_reg = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_trainer(logic [31:0] lam, logic [31:0] bs, logic [31:0] fc);
    write_reg(CFG_LAMBDA, lam);
    write_reg(CFG_BATCH, bs);
    write_reg(CFG_FCOUNT, fc);
  endtask

  // Waits until the block has nothing in flight; a trailing feature may still be moving.
  task automatic drain();
    while (feature_queue.size() > 0 || in_valid || result_queue.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_feature();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      1: return $urandom();
      2: case ($urandom_range(0, 4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return (32'($urandom_range(0, 8)) << 16) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  task automatic queue_samples(int n, int len);
    int made;
    logic [1:0] op;
    logic lb;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 49) == 0) begin
        feature_queue.push_back(sample_item_t'{op: OP_CLEAR, x: pick_feature(), lbl: 1'b0});
        made++;
      end else if ($urandom_range(0, 24) == 0) begin
        feature_queue.push_back(sample_item_t'{op: OP_NONE, x: pick_feature(),
                                               lbl: 1'($urandom_range(0, 1))});
      end else begin
        op = $urandom_range(0, 3) == 0 ? OP_PREDICT : OP_TRAIN;
        lb = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
          // Now and then a feature carries the other operation to mix a sample.
          feature_queue.push_back(sample_item_t'{
            op: ($urandom_range(0, 19) == 0) ? (op ^ 2'b01) : op,
            x: pick_feature(), lbl: ($urandom_range(0, 19) == 0) ? !lb : lb});
          made++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NFEAT; i++) feature_mem[i] = '0;
    clear_trainer();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, mixed samples, clear mid-sample.
    set_trainer(32'd65536, 32'd1, 32'd2);
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h7FFF_FFFF, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h8000_0000, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h0001_0000, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'hFFFF_0000, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h7FFF_FFFF, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h8000_0000, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h0, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h0, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h0003_0000, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h0002_0000, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_NONE, x: 32'hFFFF_FFFF, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h0000_0001, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'hFFFF_FFFF, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_TRAIN, x: 32'h1234_5678, lbl: 1'b1});
    feature_queue.push_back(sample_item_t'{op: OP_CLEAR, x: 32'h0, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h7FFF_FFFF, lbl: 1'b0});
    feature_queue.push_back(sample_item_t'{op: OP_PREDICT, x: 32'h7FFF_FFFF, lbl: 1'b0});
    drain();

    // The receiver holds off early here while the sender keeps pushing.
    set_trainer(32'd1, 32'd4, 32'd3);
    long_hold_req = 1'b1;
    queue_samples(180, 3);
    drain();

    // Zero register values act as their minimum.
    set_trainer(32'd0, 32'd0, 32'd0);
    queue_samples(24, 1);
    drain();

    set_trainer(32'hFFFF_FFFF, 32'd8, 32'd5);
    queue_samples(170, 5);
    drain();

    // Batch size above the maximum: batches rarely close.
    set_trainer(32'd65536, 32'd300, 32'd2);
    queue_samples(200, 2);
    drain();

    // Feature count above the maximum acts as the full width.
    set_trainer($urandom_range(1, 32'h0010_0000), 32'd256, 32'd100);
    queue_samples(130, 64);
    drain();

    set_trainer(32'd655, 32'd2, 32'd64);
    queue_samples(128, 64);
    drain();

    idle_off = 1'b1;
    set_trainer(32'd40000, 32'd3, 32'd4);
    queue_samples(150, 4);
    drain();
    repeat (50) @(negedge clk);

    errors += result_queue.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== linear_svm_sgd_trainer.f =====
+incdir+sv
sv/lsvm_pkg.sv
sv/lsvm_div.sv
sv/linear_svm_sgd_trainer.sv
sv/lsvm_checker.sv
test/linear_svm_sgd_trainer_tb.sv
